[hdl/assert_macros.svh]
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expectation must hold in the same cycle as the condition
`define ASSERT_SAME(label, clk, rst, cond, expect_now) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expect_now)) \
      else $error("assertion failed");

// expectation must hold in the cycle after the condition
`define ASSERT_NEXT(label, clk, rst, cond, expect_next) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expect_next)) \
      else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst, cond, expect_now)
`define ASSERT_NEXT(label, clk, rst, cond, expect_next)

`endif

`endif

[hdl/mcds_pkg.sv]
// types and constants of the midi clock to din sync converter
`default_nettype none

package mcds_pkg;

   localparam int unsigned PERIOD_BITS = 16;

   localparam int unsigned CSR_INDEX_BITS = 3;
   localparam int unsigned CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEFAULT_PULSE_US = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ACTIVITY_LED_MS  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BEAT_LED_MS      = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_MS      = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PULSES_PER_BEAT  = 3'd4;

   localparam logic [15:0] DEFAULT_PULSE_US_RESET = 16'd5000;
   localparam logic [7:0]  ACTIVITY_LED_MS_RESET  = 8'd1;
   localparam logic [7:0]  BEAT_LED_MS_RESET      = 8'd30;
   localparam logic [7:0]  DEBOUNCE_MS_RESET      = 8'd50;
   localparam logic [5:0]  PULSES_PER_BEAT_RESET  = 6'd24;

   localparam logic [7:0] MSG_CLOCK    = 8'hF8;
   localparam logic [7:0] MSG_START    = 8'hFA;
   localparam logic [7:0] MSG_CONTINUE = 8'hFB;
   localparam logic [7:0] MSG_STOP     = 8'hFC;

   typedef enum logic [1:0] {
      OP_BYTE    = 2'd0,
      OP_US_TICK = 2'd1,
      OP_MS_TICK = 2'd2
   } opcode_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] rx_byte;
      logic       switch_level;
   } req_item_type;

endpackage

`default_nettype wire

[hdl/mcds_req_if.sv]
// input channel: received bytes and timer ticks
`default_nettype none

interface mcds_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] rx_byte;
   logic       switch_level;

   modport source (output valid, output opcode, output rx_byte, output switch_level,
                   input ready);
   modport sink (input valid, input opcode, input rx_byte, input switch_level,
                 output ready);
endinterface

`default_nettype wire

[hdl/mcds_rsp_if.sv]
// result channel: sync lines and led drives
`default_nettype none

interface mcds_rsp_if;
   logic valid;
   logic ready;
   logic sync_clock;
   logic sync_run;
   logic activity_led;
   logic beat_led;

   modport source (output valid, output sync_clock, output sync_run, output activity_led,
                   output beat_led, input ready);
   modport sink (input valid, input sync_clock, input sync_run, input activity_led,
                 input beat_led, output ready);
endinterface

`default_nettype wire

[hdl/midi_clock_to_din_sync_top.sv]
// midi clock to din sync24 converter, top level
// path: an item taken is held in the input register and is applied to the state
// when the result register is free or being emptied; the result is registered
// throughput: one item per cycle from one update pass, unless rsp_chan stalls
// reset: synchronous, active high; clears the state but sets timer_on, loads register defaults
`default_nettype none
`include "assert_macros.svh"

module midi_clock_to_din_sync_top (
   input  logic clock,
   input  logic reset,
   mcds_req_if.sink   req_chan,
   mcds_rsp_if.source rsp_chan,
   input  logic                                   csr_wr_en,
   input  logic [mcds_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [mcds_pkg::CSR_DATA_BITS-1:0]     csr_wr_data
);

   localparam int unsigned PB = mcds_pkg::PERIOD_BITS;

   // configuration
   logic [15:0] default_pulse_us_ff;
   logic [7:0]  activity_led_ms_ff;
   logic [7:0]  beat_led_ms_ff;
   logic [7:0]  debounce_ms_ff;
   logic [5:0]  pulses_per_beat_ff;

   // handshake and input register
   logic                   item_valid_ff, item_valid_in;
   mcds_pkg::req_item_type item_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   advance, fire, req_accept;

   // converter state
   logic          clock_level_ff, clock_level_in;
   logic          run_flag_ff, run_flag_in;
   logic          timer_on_ff, timer_on_in;
   logic [PB-1:0] period_count_ff, period_count_in;
   logic [PB-1:0] pulse_end_ff, pulse_end_in;
   logic [5:0]    beat_pulse_count_ff, beat_pulse_count_in;
   logic [7:0]    activity_left_ff, activity_left_in;
   logic [7:0]    beat_left_ff, beat_left_in;
   logic [7:0]    debounce_left_ff, debounce_left_in;
   logic          await_release_ff, await_release_in;
   logic          activity_led_ff, activity_led_in;
   logic          beat_led_ff, beat_led_in;

   logic [PB-1:0] count_step;
   logic [5:0]    pulse_step;
   logic          start_run;

   always_ff @(posedge clock) begin
      if (reset) begin
         default_pulse_us_ff <= mcds_pkg::DEFAULT_PULSE_US_RESET;
         activity_led_ms_ff  <= mcds_pkg::ACTIVITY_LED_MS_RESET;
         beat_led_ms_ff      <= mcds_pkg::BEAT_LED_MS_RESET;
         debounce_ms_ff      <= mcds_pkg::DEBOUNCE_MS_RESET;
         pulses_per_beat_ff  <= mcds_pkg::PULSES_PER_BEAT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            mcds_pkg::CSR_DEFAULT_PULSE_US: default_pulse_us_ff <= csr_wr_data;
            mcds_pkg::CSR_ACTIVITY_LED_MS:  activity_led_ms_ff  <= csr_wr_data[7:0];
            mcds_pkg::CSR_BEAT_LED_MS:      beat_led_ms_ff      <= csr_wr_data[7:0];
            mcds_pkg::CSR_DEBOUNCE_MS:      debounce_ms_ff      <= csr_wr_data[7:0];
            mcds_pkg::CSR_PULSES_PER_BEAT:  pulses_per_beat_ff  <= csr_wr_data[5:0];
            default: ;
         endcase
      end
   end

   // the item register moves on when the result register is free or being emptied
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign fire           = item_valid_ff && advance;
   assign req_chan.ready = !item_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   assign item_valid_in = req_accept ? 1'b1 : (fire ? 1'b0 : item_valid_ff);
   assign rsp_valid_in  = fire ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff.opcode       <= req_chan.opcode;
         item_ff.rx_byte      <= req_chan.rx_byte;
         item_ff.switch_level <= req_chan.switch_level;
      end
   end

   assign count_step = period_count_ff + PB'(1);
   assign pulse_step = beat_pulse_count_ff + 6'd1;

   always_comb begin
      clock_level_in      = clock_level_ff;
      run_flag_in         = run_flag_ff;
      timer_on_in         = timer_on_ff;
      period_count_in     = period_count_ff;
      pulse_end_in        = pulse_end_ff;
      beat_pulse_count_in = beat_pulse_count_ff;
      activity_left_in    = activity_left_ff;
      beat_left_in        = beat_left_ff;
      debounce_left_in    = debounce_left_ff;
      await_release_in    = await_release_ff;
      activity_led_in     = activity_led_ff;
      beat_led_in         = beat_led_ff;
      start_run           = 1'b0;
      if (fire) begin
         unique case (item_ff.opcode)
            mcds_pkg::OP_BYTE: begin
               if (item_ff.rx_byte == mcds_pkg::MSG_CLOCK) begin
                  clock_level_in  = 1'b1;
                  // half the measured gap, else the configured width
                  pulse_end_in    = timer_on_ff ? (period_count_ff >> 1)
                                                : PB'(default_pulse_us_ff);
                  period_count_in = '0;
                  timer_on_in     = 1'b1;
                  if (pulse_step == pulses_per_beat_ff) begin
                     beat_pulse_count_in = '0;
                     beat_left_in        = beat_led_ms_ff;
                  end else begin
                     beat_pulse_count_in = pulse_step;
                  end
                  activity_left_in = activity_led_ms_ff;
               end else if (item_ff.rx_byte == mcds_pkg::MSG_START ||
                            item_ff.rx_byte == mcds_pkg::MSG_CONTINUE) begin
                  start_run = 1'b1;
               end else if (item_ff.rx_byte == mcds_pkg::MSG_STOP) begin
                  run_flag_in = 1'b0;
               end
            end
            mcds_pkg::OP_US_TICK: begin
               if (clock_level_ff && pulse_end_ff == '0) begin
                  clock_level_in = 1'b0;
               end
               if (timer_on_ff) begin
                  period_count_in = count_step;
                  // timer stops once it wraps
                  if (count_step == '0) begin
                     timer_on_in = 1'b0;
                  end
                  if (count_step == pulse_end_ff) begin
                     clock_level_in = 1'b0;
                  end
               end
            end
            mcds_pkg::OP_MS_TICK: begin
               activity_led_in = activity_left_ff != 8'd0;
               beat_led_in     = run_flag_ff && beat_left_ff != 8'd0;
               if (activity_left_ff != 8'd0) begin
                  activity_left_in = activity_left_ff - 8'd1;
               end
               if (beat_left_ff != 8'd0) begin
                  beat_left_in = beat_left_ff - 8'd1;
               end
               if (!await_release_ff) begin
                  if (debounce_left_ff != 8'd0) begin
                     debounce_left_in = debounce_left_ff - 8'd1;
                  end else if (item_ff.switch_level) begin
                     await_release_in = 1'b1;
                  end
               end else if (!item_ff.switch_level) begin
                  // release after an armed press toggles run
                  if (run_flag_ff) begin
                     run_flag_in = 1'b0;
                  end else begin
                     start_run = 1'b1;
                  end
                  debounce_left_in = debounce_ms_ff;
                  await_release_in = 1'b0;
               end
            end
            default: ;
         endcase
         if (start_run) begin
            run_flag_in         = 1'b1;
            beat_pulse_count_in = '0;
            beat_left_in        = beat_led_ms_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff       <= 1'b0;
         rsp_valid_ff        <= 1'b0;
         clock_level_ff      <= 1'b0;
         run_flag_ff         <= 1'b0;
         timer_on_ff         <= 1'b1;
         period_count_ff     <= '0;
         pulse_end_ff        <= '0;
         beat_pulse_count_ff <= '0;
         activity_left_ff    <= '0;
         beat_left_ff        <= '0;
         debounce_left_ff    <= '0;
         await_release_ff    <= 1'b0;
         activity_led_ff     <= 1'b0;
         beat_led_ff         <= 1'b0;
      end else begin
         item_valid_ff       <= item_valid_in;
         rsp_valid_ff        <= rsp_valid_in;
         clock_level_ff      <= clock_level_in;
         run_flag_ff         <= run_flag_in;
         timer_on_ff         <= timer_on_in;
         period_count_ff     <= period_count_in;
         pulse_end_ff        <= pulse_end_in;
         beat_pulse_count_ff <= beat_pulse_count_in;
         activity_left_ff    <= activity_left_in;
         beat_left_ff        <= beat_left_in;
         debounce_left_ff    <= debounce_left_in;
         await_release_ff    <= await_release_in;
         activity_led_ff     <= activity_led_in;
         beat_led_ff         <= beat_led_in;
      end
   end

   // state only moves when a result is loaded, so it is the held result
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.sync_clock   = clock_level_ff;
   assign rsp_chan.sync_run     = run_flag_ff;
   assign rsp_chan.activity_led = activity_led_ff;
   assign rsp_chan.beat_led     = beat_led_ff;

   `ASSERT_SAME(a_stopped_timer_zero, clock, reset, !timer_on_ff, period_count_ff == '0)
   `ASSERT_SAME(a_armed_no_debounce, clock, reset, await_release_ff, debounce_left_ff == 8'd0)
   `ASSERT_NEXT(a_accept_fills_item, clock, reset, req_accept, item_valid_ff)
   `ASSERT_NEXT(a_clock_byte_raises, clock, reset,
      fire && item_ff.opcode == mcds_pkg::OP_BYTE && item_ff.rx_byte == mcds_pkg::MSG_CLOCK,
      clock_level_ff && rsp_valid_ff)

endmodule

`default_nettype wire
